// ===== rtl/sssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_pkg: shared types and constants for the four-digit display driver
// Command codes, BCD digit vector type and port byte select codes.
// ----------------------------------------------------------------------------
package sssd_pkg;

	localparam int unsigned NUM_DIGITS = 4;
	localparam int unsigned VALUE_W    = 14;

	typedef logic [3:0] bcd_t;
	typedef logic [NUM_DIGITS-1:0][3:0] digit_vec_t;
	typedef logic [1:0] pos_t;
	typedef logic [VALUE_W-1:0] value_t;

	typedef enum logic [1:0] {
		CMD_SET    = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_SCAN   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	localparam bcd_t       BLANK_LOW  = 4'hF;
	localparam logic [7:0] PORT_RESET = 8'hFF;

	// active-low one-hot digit select, upper nibble of the port byte
	function automatic logic [3:0] select_code(input pos_t pos);
		logic [3:0] sel;
		unique case (pos)
			2'd0: sel = 4'hE;
			2'd1: sel = 4'hD;
			2'd2: sel = 4'hB;
			2'd3: sel = 4'h7;
			default: sel = 4'hF;
		endcase
		return sel;
	endfunction

endpackage

// ===== rtl/sssd_bin2bcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssd_bin2bcd: 16-bit binary to four BCD digits, modulo 10000
// Parallel compares against constant multiples, one subtract per place.
// ----------------------------------------------------------------------------
module sssd_bin2bcd (
	input  logic [15:0]          bin,
	output sssd_pkg::digit_vec_t digits,
	output sssd_pkg::value_t     value
);

	logic [13:0] rem0;
	logic [9:0]  rem1;
	logic [6:0]  rem2;
	logic [3:0]  rem3;
	logic [3:0]  d3, d2, d1;

	// modulo 10000: quotient is at most 6
	always_comb begin
		rem0 = bin[13:0];
		for (int k = 1; k <= 6; k++) begin
			if (bin >= 16'(k * 10000)) begin
				rem0 = 14'(bin - 16'(k * 10000));
			end
		end
	end

	always_comb begin
		d3   = 4'd0;
		rem1 = rem0[9:0];
		for (int k = 1; k <= 9; k++) begin
			if (rem0 >= 14'(k * 1000)) begin
				d3   = 4'(k);
				rem1 = 10'(rem0 - 14'(k * 1000));
			end
		end
	end

	always_comb begin
		d2   = 4'd0;
		rem2 = rem1[6:0];
		for (int k = 1; k <= 9; k++) begin
			if (rem1 >= 10'(k * 100)) begin
				d2   = 4'(k);
				rem2 = 7'(rem1 - 10'(k * 100));
			end
		end
	end

	always_comb begin
		d1   = 4'd0;
		rem3 = rem2[3:0];
		for (int k = 1; k <= 9; k++) begin
			if (rem2 >= 7'(k * 10)) begin
				d1   = 4'(k);
				rem3 = 4'(rem2 - 7'(k * 10));
			end
		end
	end

	assign digits = {d3, d2, d1, rem3};
	assign value  = rem0;

endmodule

// ===== rtl/seven_segment_scan_with_decimal_entry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_with_decimal_entry: four-digit multiplexed display driver
// Keeps a decimal value (set or keyed in digit by digit) and scans it out.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   item     | item_valid, item_stall, command,     | in
//            | set_value, key_digit                 |
//   result   | result_valid, result_stall,          | out
//            | port_drive, shown_value,             |
//            | value_present                        |
//
// One transfer in gives exactly one result transfer: it passes the input
// register, then goes through the command logic into the result register.
// A new item is taken every cycle unless item_stall is raised; the depth of
// the binary-to-BCD conversion on a set command sets the clock period.
// Reset (arst_n low) blanks the display and sets the port byte to 0xFF.
// result_stall holds the result register; item_stall rises only when both
// the input and the result register are full and the result is stalled.
// ----------------------------------------------------------------------------
module seven_segment_scan_with_decimal_entry (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  command,
	input  logic [15:0] set_value,
	input  logic [3:0]  key_digit,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  port_drive,
	output logic [13:0] shown_value,
	output logic        value_present
);

	// input register
	logic              valid_s1;
	sssd_pkg::cmd_t    command_s1;
	logic [15:0]       set_value_s1;
	logic [3:0]        key_digit_s1;

	// result register
	logic              valid_s2;
	logic [7:0]        port_s2;
	sssd_pkg::value_t  value_s2;
	logic              present_s2;

	// display state
	sssd_pkg::digit_vec_t digits_q;   // BCD, zero above the top digit
	sssd_pkg::pos_t       top_q;      // most significant shown digit
	logic                 present_q;  // any digit shown
	sssd_pkg::pos_t       scan_q;
	logic [7:0]           port_q;
	sssd_pkg::value_t     value_q;

	logic advance;
	logic load_s1;

	// stage 1 moves on when the result register is empty or being drained
	assign advance    = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign load_s1    = !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && item_valid) begin
			command_s1   <= sssd_pkg::cmd_t'(command);
			set_value_s1 <= set_value;
			key_digit_s1 <= key_digit;
		end
	end

	// ---------------- set path: binary to BCD ----------------
	sssd_pkg::digit_vec_t set_digits;
	sssd_pkg::value_t     set_val;

	sssd_bin2bcd u_bin2bcd (
		.bin    (set_value_s1),
		.digits (set_digits),
		.value  (set_val)
	);

	// ---------------- append path: BCD shift and add ----------------
	// Shift one place left (thousands digit drops out), put the key in the
	// units place. A key of ten or more leaves key-10 there and carries a
	// one into the tens place, rippling through nines.
	sssd_pkg::digit_vec_t app_digits;
	sssd_pkg::value_t     app_val;
	logic                 carry;

	always_comb begin
		app_digits = {digits_q[2], digits_q[1], digits_q[0], 4'd0};
		carry      = 1'b0;
		if (key_digit_s1 >= 4'd10) begin
			app_digits[0] = key_digit_s1 - 4'd10;
			carry         = 1'b1;
		end else begin
			app_digits[0] = key_digit_s1;
		end
		for (int i = 1; i < sssd_pkg::NUM_DIGITS; i++) begin
			if (carry) begin
				if (app_digits[i] == 4'd9) begin
					app_digits[i] = 4'd0;
				end else begin
					app_digits[i] = app_digits[i] + 4'd1;
					carry         = 1'b0;
				end
			end
		end
	end

	// BCD back to binary: constant weights only
	assign app_val = 14'(app_digits[3]) * 14'd1000 + 14'(app_digits[2]) * 14'd100
		+ 14'(app_digits[1]) * 14'd10 + 14'(app_digits[0]);

	// ---------------- load selection and top digit ----------------
	logic                 is_load;
	sssd_pkg::digit_vec_t new_digits;
	sssd_pkg::value_t     new_val;
	sssd_pkg::pos_t       new_top;

	assign is_load    = (command_s1 == sssd_pkg::CMD_SET) || (command_s1 == sssd_pkg::CMD_APPEND);
	assign new_digits = (command_s1 == sssd_pkg::CMD_SET) ? set_digits : app_digits;
	assign new_val    = (command_s1 == sssd_pkg::CMD_SET) ? set_val : app_val;

	// highest nonzero digit; zero shows as a single 0 in the units place
	always_comb begin
		new_top = 2'd0;
		for (int i = 1; i < sssd_pkg::NUM_DIGITS; i++) begin
			if (new_digits[i] != 4'd0) begin
				new_top = sssd_pkg::pos_t'(i);
			end
		end
	end

	// ---------------- scan path ----------------
	logic [3:0] scan_low;
	logic [7:0] scan_port;

	assign scan_low  = (present_q && (scan_q <= top_q)) ? digits_q[scan_q]
		: sssd_pkg::BLANK_LOW;
	assign scan_port = {sssd_pkg::select_code(scan_q), scan_low};

	// ---------------- next state and result ----------------
	logic                 fire;
	logic [7:0]           port_next;
	sssd_pkg::value_t     value_next;
	logic                 present_next;

	assign fire         = valid_s1 && advance;
	assign port_next    = (command_s1 == sssd_pkg::CMD_SCAN) ? scan_port : port_q;
	assign value_next   = is_load ? new_val : value_q;
	assign present_next = is_load || present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q  <= '0;
			top_q     <= '0;
			present_q <= 1'b0;
			scan_q    <= '0;
			port_q    <= sssd_pkg::PORT_RESET;
			value_q   <= '0;
		end else if (fire) begin
			unique case (command_s1)
				sssd_pkg::CMD_SET, sssd_pkg::CMD_APPEND: begin
					digits_q  <= new_digits;
					top_q     <= new_top;
					present_q <= 1'b1;
					value_q   <= new_val;
				end
				sssd_pkg::CMD_SCAN: begin
					port_q <= scan_port;
					scan_q <= scan_q + 2'd1;
				end
				sssd_pkg::CMD_NOP: begin
					// unused code: state holds
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			port_s2    <= port_next;
			value_s2   <= value_next;
			present_s2 <= present_next;
		end
	end

	assign result_valid  = valid_s2;
	assign port_drive    = port_s2;
	assign shown_value   = value_s2;
	assign value_present = present_s2;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the four-digit scanned display driver
// Feeds set, append, scan and unused commands through the item channel,
// predicts each readout with an independent display model and checks every
// result field in order. Both channels see random idle and stall bursts.
// ----------------------------------------------------------------------------
module tb_top;

	// one command transfer on the item channel
	typedef struct packed {
		sssd_pkg::cmd_t command;
		logic [15:0]    set_value;
		sssd_pkg::bcd_t key_digit;
	} cmd_item_t;

	// one readout transfer on the result channel
	typedef struct packed {
		logic [7:0]       port_drive;
		sssd_pkg::value_t shown_value;
		logic             value_present;
	} readout_t;

	localparam logic [2:0]     NO_TOP      = 3'd7;   // no digit shown
	localparam sssd_pkg::bcd_t BLANK_DIGIT = 4'd10;  // stored code for a blank position
	localparam int             TAIL_ITEMS  = 150;    // last stretch runs with no idling
	localparam int             DRAIN_CYCLES = 8;

	// digit select per scan position, active low, upper nibble
	localparam logic [7:0] SEL_BYTE [4] = '{8'hE0, 8'hD0, 8'hB0, 8'h70};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  command = sssd_pkg::CMD_NOP;
	logic [15:0] set_value = '0;
	logic [3:0]  key_digit = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  port_drive;
	logic [13:0] shown_value;
	logic        value_present;

	seven_segment_scan_with_decimal_entry dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.set_value    (set_value),
		.key_digit    (key_digit),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.port_drive   (port_drive),
		.shown_value  (shown_value),
		.value_present(value_present)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Display model: digit store (units first), top digit index, scan
	// position and the last port byte driven.
	// ------------------------------------------------------------------
	sssd_pkg::bcd_t shown_digits [4];
	logic [2:0]     top_pos;
	sssd_pkg::pos_t scan_pos;
	logic [7:0]     port_last;

	function automatic void clear_display();
		for (int i = 0; i < 4; i++)
			shown_digits[i] = BLANK_DIGIT;
		top_pos   = NO_TOP;
		scan_pos  = '0;
		port_last = sssd_pkg::PORT_RESET;
	endfunction

	// value of the shown digits, blanks count as nothing
	function automatic int unsigned shown_decimal();
		int unsigned total = 0;
		int unsigned weight = 1;
		if (top_pos == NO_TOP)
			return 0;
		for (int i = 0; i < 4; i++) begin
			if (i <= top_pos && shown_digits[i] < BLANK_DIGIT)
				total += shown_digits[i] * weight;
			weight *= 10;
		end
		return total;
	endfunction

	// show a value modulo 10000, leading zeros blank, zero as a single 0
	function automatic void load_decimal(input int unsigned val);
		sssd_pkg::bcd_t dig [4];
		int unsigned    rest;
		int             top;
		rest = val % 10000;
		top  = 0;
		for (int i = 0; i < 4; i++) begin
			dig[i] = sssd_pkg::bcd_t'(rest % 10);
			rest   = rest / 10;
		end
		for (int i = 0; i < 4; i++)
			if (dig[i] != 0)
				top = i;
		for (int i = 0; i < 4; i++)
			shown_digits[i] = (i <= top) ? dig[i] : BLANK_DIGIT;
		top_pos = 3'(top);
	endfunction

	// apply one command to the model and return the readout it gives
	function automatic readout_t apply_command(input cmd_item_t it);
		readout_t       ro;
		sssd_pkg::bcd_t d;
		case (it.command)
			sssd_pkg::CMD_SET: load_decimal(it.set_value);
			sssd_pkg::CMD_APPEND: begin
				// with nothing shown the key value is taken as it is
				if (top_pos != NO_TOP)
					load_decimal(shown_decimal() * 10 + it.key_digit);
				else
					load_decimal(it.key_digit);
			end
			sssd_pkg::CMD_SCAN: begin
				d         = shown_digits[scan_pos];
				port_last = SEL_BYTE[scan_pos]
					| ((d < BLANK_DIGIT) ? {4'h0, d} : {4'h0, sssd_pkg::BLANK_LOW});
				scan_pos  = scan_pos + 2'd1;
			end
			default: ;  // unused command leaves the display alone
		endcase
		ro.port_drive    = port_last;
		ro.shown_value   = sssd_pkg::value_t'(shown_decimal());
		ro.value_present = (top_pos != NO_TOP);
		return ro;
	endfunction

	cmd_item_t pending_cmds [$];
	readout_t  expected_readouts [$];
	int        fail_count = 0;
	logic      quiet_tail = 1'b0;

	// ------------------------------------------------------------------
	// Driver: one command per transfer. The model advances on the edge
	// the transfer is taken, so expectations stay in item order. Valid
	// only drops between transfers; a stalled item is held unchanged.
	// ------------------------------------------------------------------
	int        idle_left;
	cmd_item_t next_cmd;
	cmd_item_t taken_cmd;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			command    <= sssd_pkg::CMD_NOP;
			set_value  <= '0;
			key_digit  <= '0;
			quiet_tail <= 1'b0;
			idle_left  = 0;
			clear_display();
		end else begin
			if (item_valid && !item_stall) begin
				taken_cmd.command   = sssd_pkg::cmd_t'(command);
				taken_cmd.set_value = set_value;
				taken_cmd.key_digit = key_digit;
				expected_readouts.push_back(apply_command(taken_cmd));
			end
			quiet_tail <= (pending_cmds.size() < TAIL_ITEMS);
			if (!item_valid || !item_stall) begin
				if (idle_left > 0) begin
					idle_left--;
					item_valid <= 1'b0;
				end else if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
					// start an idle burst, this transfer slot included
					idle_left  = $urandom_range(1, 18) - 1;
					item_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					next_cmd   = pending_cmds.pop_front();
					command    <= next_cmd.command;
					set_value  <= next_cmd.set_value;
					key_digit  <= next_cmd.key_digit;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compares each readout transfer with the oldest expectation
	// and throws stall bursts at the result channel.
	// ------------------------------------------------------------------
	int       stall_left;
	readout_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_readouts.size() == 0) begin
					$error("unexpected readout: port_drive %h shown_value %0d value_present %b",
						port_drive, shown_value, value_present);
					fail_count++;
				end else begin
					want = expected_readouts.pop_front();
					if (port_drive !== want.port_drive) begin
						$error("port_drive: expected %h, actual %h", want.port_drive, port_drive);
						fail_count++;
					end
					if (shown_value !== want.shown_value) begin
						$error("shown_value: expected %0d, actual %0d",
							want.shown_value, shown_value);
						fail_count++;
					end
					if (value_present !== want.value_present) begin
						$error("value_present: expected %b, actual %b",
							want.value_present, value_present);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
				stall_left   = $urandom_range(1, 18) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic void queue_cmd(input sssd_pkg::cmd_t c, input logic [15:0] v,
		input sssd_pkg::bcd_t k);
		cmd_item_t it;
		it.command   = c;
		it.set_value = v;
		it.key_digit = k;
		pending_cmds.push_back(it);
	endfunction

	// random filler for the fields a command does not use
	function automatic logic [15:0] rnd_value();
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic sssd_pkg::bcd_t rnd_key();
		// mostly proper digits, now and then 10 to 15
		return ($urandom_range(0, 7) == 0) ? sssd_pkg::bcd_t'($urandom_range(10, 15))
		                                   : sssd_pkg::bcd_t'($urandom_range(0, 9));
	endfunction

	function automatic void queue_random(input int n);
		int          pick;
		logic [15:0] v;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				queue_cmd(sssd_pkg::CMD_SCAN, rnd_value(), rnd_key());
			end else if (pick < 70) begin
				queue_cmd(sssd_pkg::CMD_APPEND, rnd_value(), rnd_key());
			end else if (pick < 94) begin
				case ($urandom_range(0, 4))
					0: v = 16'd0;
					1: v = 16'($urandom_range(0, 99));
					2: v = 16'($urandom_range(0, 6) * 10000);
					default: v = rnd_value();
				endcase
				queue_cmd(sssd_pkg::CMD_SET, v, rnd_key());
			end else begin
				queue_cmd(sssd_pkg::CMD_NOP, rnd_value(), rnd_key());
			end
		end
	endfunction

	initial begin
		// directed: reset readout, blanks scanned, append on empty display
		// (key above nine), zero, carries, wrap of set and append values
		queue_cmd(sssd_pkg::CMD_NOP,    16'hFFFF, 4'hF);
		queue_cmd(sssd_pkg::CMD_SCAN,   16'h0000, 4'h0);
		queue_cmd(sssd_pkg::CMD_APPEND, 16'h0000, 4'd12);
		queue_cmd(sssd_pkg::CMD_SCAN,   16'h0000, 4'h0);
		queue_cmd(sssd_pkg::CMD_SCAN,   16'h0000, 4'h0);
		queue_cmd(sssd_pkg::CMD_SCAN,   16'h0000, 4'h0);
		queue_cmd(sssd_pkg::CMD_SET,    16'd0,    4'h0);
		queue_cmd(sssd_pkg::CMD_SCAN,   16'h0000, 4'h0);
		queue_cmd(sssd_pkg::CMD_APPEND, 16'h0000, 4'd0);
		queue_cmd(sssd_pkg::CMD_APPEND, 16'h0000, 4'd7);
		queue_cmd(sssd_pkg::CMD_SET,    16'd9999, 4'h0);
		queue_cmd(sssd_pkg::CMD_APPEND, 16'h0000, 4'd15);
		queue_cmd(sssd_pkg::CMD_SET,    16'hFFFF, 4'h0);
		queue_cmd(sssd_pkg::CMD_APPEND, 16'h0000, 4'd9);
		queue_cmd(sssd_pkg::CMD_SCAN,   16'h0000, 4'h0);
		queue_cmd(sssd_pkg::CMD_SCAN,   16'h0000, 4'h0);
		queue_cmd(sssd_pkg::CMD_SCAN,   16'h0000, 4'h0);
		queue_cmd(sssd_pkg::CMD_SCAN,   16'h0000, 4'h0);
		queue_cmd(sssd_pkg::CMD_SET,    16'd10000, 4'h0);
		queue_cmd(sssd_pkg::CMD_SET,    16'd1234, 4'h0);
		queue_cmd(sssd_pkg::CMD_APPEND, 16'h0000, 4'd10);
		queue_cmd(sssd_pkg::CMD_SET,    16'h8000, 4'h0);
		queue_cmd(sssd_pkg::CMD_NOP,    16'h0000, 4'h0);
		queue_random(1150);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// all commands taken, then all readouts back, then a short drain
		// to catch any stray result
		while (pending_cmds.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_readouts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// stop the run if it hangs
	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sssd_pkg.sv
rtl/sssd_bin2bcd.sv
rtl/seven_segment_scan_with_decimal_entry.sv
tb/tb_top.sv
